[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// Clocked assertions with reset masking, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ssm_pkg.sv]
// ----------------------------------------------------------------------------
// ssm_pkg
// Constants, register codes and byte compare helpers of the substring matcher.
// ----------------------------------------------------------------------------
package ssm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int REG_BYTES   = 32;
    localparam int WORD_W      = 64;
    localparam int NUM_WORDS   = 4;
    localparam int LEN_REG_W   = 6;
    localparam int POS_W       = 32;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int HIST_DEPTH  = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;

    typedef enum logic [2:0] {
        REG_PAT_WORD0   = 3'd0,
        REG_PAT_WORD1   = 3'd1,
        REG_PAT_WORD2   = 3'd2,
        REG_PAT_WORD3   = 3'd3,
        REG_PAT_LENGTH  = 3'd4,
        REG_IGNORE_CASE = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic shift_en;
        logic clear;
        logic ignore_case;
    } hist_ctrl_t;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic bytes_equal(input logic [7:0] a, input logic [7:0] b,
                                         input logic ic);
        logic eq;
        if (ic)
        begin
            eq = (lower_ascii(a) == lower_ascii(b));
        end
        else
        begin
            eq = (a == b);
        end
        return eq;
    endfunction

    // Byte idx of the pattern; bytes past the register file read as zero
    function automatic logic [7:0] pattern_byte(input logic [REG_BYTES*8-1:0] pat,
                                                input logic [LEN_W-1:0] idx);
        logic [7:0]  r;
        logic [31:0] idx_ext;
        r       = 8'd0;
        idx_ext = 32'(idx);
        for (int i = 0; i < REG_BYTES; i++)
        begin
            if (idx_ext == 32'(i))
            begin
                r = pat[i*8 +: 8];
            end
        end
        return r;
    endfunction

endpackage

[rtl/ssm_cell.sv]
// ----------------------------------------------------------------------------
// ssm_cell
// One history cell: holds a past text byte, shifts it on, compares it.
// ----------------------------------------------------------------------------
module ssm_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ssm_pkg::hist_ctrl_t ctrl,
    input  logic [7:0]          byte_in,
    input  logic [7:0]          pat_byte,
    input  logic                active,
    output logic [7:0]          byte_out,
    output logic                hit
);

    logic [7:0] hist_reg;
    logic [7:0] hist_next;

    always_comb
    begin
        hist_next = hist_reg;
        if (ctrl.clear)
        begin
            hist_next = 8'd0;
        end
        else if (ctrl.shift_en)
        begin
            hist_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= 8'd0;
        end
        else
        begin
            hist_reg <= hist_next;
        end
    end

    assign byte_out = hist_reg;
    assign hit      = !active || ssm_pkg::bytes_equal(pat_byte, hist_reg, ctrl.ignore_case);

endmodule

[rtl/stream_substring_matcher_core.sv]
// ----------------------------------------------------------------------------
// stream_substring_matcher_core
// Streaming substring search, exact or case-insensitive, with overlapping matches.
// ----------------------------------------------------------------------------
// Text enters on the s_ stream, one byte per transfer (s_tdata[7:0] = text
// byte, s_tlast = final byte of a text). Results leave on the m_ stream:
// m_tdata = match start offset, m_tuser[0] = match found, m_tlast = end of
// text. A result is produced when a pattern occurrence ends on the byte or
// the byte is the last of its text; other bytes produce nothing.
// The pattern (up to 32 bytes), its length and the case mode are written
// over the APB port at byte addresses 0, 8, .., 40.
// The result is registered and appears in the cycle after the input
// transfer. A new byte is taken every cycle unless the receiver stalls:
// the window compare against the history cells is combinational.
// Reset clears the history cells, the offset counter, the registers and
// the output register. While the receiver stalls, the held result stays
// in the output register and s_tready drops until it is taken.
// ----------------------------------------------------------------------------
module stream_substring_matcher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] match_start
    output logic [0:0]  m_tuser,   // [0] match_found
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int LEN_W = ssm_pkg::LEN_W;
    localparam int POS_W = ssm_pkg::POS_W;
    localparam int DEPTH = ssm_pkg::HIST_DEPTH;

    logic [ssm_pkg::WORD_W-1:0]    pat_word_reg [ssm_pkg::NUM_WORDS];
    logic [ssm_pkg::LEN_REG_W-1:0] pat_len_reg;
    logic                          ignore_case_reg;
    ssm_pkg::reg_idx_t             reg_idx;
    logic                          cfg_write;

    logic [ssm_pkg::REG_BYTES*8-1:0] pat_flat;
    logic [LEN_W-1:0]                len_eff;
    logic [POS_W-1:0]                len_ext;
    logic [POS_W-1:0]                pos_reg;
    logic [POS_W-1:0]                pos_next;

    logic               accept;
    logic               eq_cur;
    logic               pos_ok;
    logic               found;
    logic               produce;
    logic [POS_W-1:0]   start;
    ssm_pkg::hist_ctrl_t ctrl;

    logic [7:0] cell_byte [DEPTH];
    logic [DEPTH-1:0] cell_hit;

    logic             m_tvalid_reg;
    logic [POS_W-1:0] m_start_reg;
    logic             m_found_reg;
    logic             m_last_reg;

    // ---------------- configuration registers ----------------
    assign pready    = 1'b1;
    assign reg_idx   = ssm_pkg::reg_idx_t'(paddr[5:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ssm_pkg::NUM_WORDS; i++)
            begin
                pat_word_reg[i] <= '0;
            end
            pat_len_reg     <= '0;
            ignore_case_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                ssm_pkg::REG_PAT_WORD0:   pat_word_reg[0] <= pwdata;
                ssm_pkg::REG_PAT_WORD1:   pat_word_reg[1] <= pwdata;
                ssm_pkg::REG_PAT_WORD2:   pat_word_reg[2] <= pwdata;
                ssm_pkg::REG_PAT_WORD3:   pat_word_reg[3] <= pwdata;
                ssm_pkg::REG_PAT_LENGTH:  pat_len_reg <= pwdata[ssm_pkg::LEN_REG_W-1:0];
                ssm_pkg::REG_IGNORE_CASE: ignore_case_reg <= pwdata[0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ssm_pkg::REG_PAT_WORD0:   prdata = pat_word_reg[0];
            ssm_pkg::REG_PAT_WORD1:   prdata = pat_word_reg[1];
            ssm_pkg::REG_PAT_WORD2:   prdata = pat_word_reg[2];
            ssm_pkg::REG_PAT_WORD3:   prdata = pat_word_reg[3];
            ssm_pkg::REG_PAT_LENGTH:  prdata = 64'(pat_len_reg);
            ssm_pkg::REG_IGNORE_CASE: prdata = 64'(ignore_case_reg);
            default:                  prdata = 64'd0;
        endcase
    end

    assign pat_flat = {pat_word_reg[3], pat_word_reg[2], pat_word_reg[1], pat_word_reg[0]};

    // Length clamped to the window size
    always_comb
    begin
        if (32'(pat_len_reg) > 32'(ssm_pkg::PATTERN_MAX))
        begin
            len_eff = LEN_W'(ssm_pkg::PATTERN_MAX);
        end
        else
        begin
            len_eff = LEN_W'(pat_len_reg);
        end
    end

    assign len_ext = POS_W'(len_eff);

    // ---------------- window compare ----------------
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign ctrl.shift_en    = accept && !s_tlast;
    assign ctrl.clear       = accept && s_tlast;
    assign ctrl.ignore_case = ignore_case_reg;

    assign eq_cur = ssm_pkg::bytes_equal(
        ssm_pkg::pattern_byte(pat_flat, len_eff - LEN_W'(1)), s_tdata, ignore_case_reg);

    // Cell k holds the byte seen k+1 transfers ago
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic       act;
        logic [7:0] pbyte;

        assign act   = (32'(k + 1) < 32'(len_eff));
        assign pbyte = ssm_pkg::pattern_byte(pat_flat, len_eff - LEN_W'(k + 2));

        ssm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .byte_in  ((k == 0) ? s_tdata : cell_byte[(k == 0) ? 0 : k - 1]),
            .pat_byte (pbyte),
            .active   (act),
            .byte_out (cell_byte[k]),
            .hit      (cell_hit[k])
        );
    end

    assign pos_ok  = (len_eff != '0) && (pos_reg >= (len_ext - POS_W'(1)));
    assign found   = pos_ok && eq_cur && (&cell_hit);
    assign start   = pos_reg - (len_ext - POS_W'(1));
    assign produce = found || s_tlast;

    // ---------------- offset counter ----------------
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                pos_next = '0;
            end
            else if (pos_reg != '1)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_tvalid_reg <= accept && produce;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_start_reg <= '0;
            m_found_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end
        else if (accept && produce)
        begin
            m_start_reg <= found ? start : '0;
            m_found_reg <= found;
            m_last_reg  <= s_tlast;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_start_reg;
    assign m_tuser[0] = m_found_reg;
    assign m_tlast    = m_last_reg;

endmodule

[rtl/ssm_checker.sv]
// ----------------------------------------------------------------------------
// ssm_checker
// Port-level checks of the substring matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast,
    input logic        pready
);

    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `ASSERT_IMPLIES(a_result_cause, m_tvalid, m_tuser[0] || m_tlast, "result with neither match nor end of text")
    `ASSERT_IMPLIES(a_start_zero, m_tvalid && !m_tuser[0], m_tdata == 32'd0, "nonzero start without match")
    `ASSERT_IMPLIES(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")
    `ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind stream_substring_matcher_core ssm_checker u_ssm_checker (.*);
